@@ src/bcs_pkg.sv @@
`timescale 1ns / 1ps

package bcs_pkg;

  // configuration register widths and reset values
  localparam int SAMPLE_COUNT_W = 7;
  localparam int T_STEP_W       = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;

  localparam logic [SAMPLE_COUNT_W-1:0] SAMPLE_COUNT_RST = 7'd64;
  localparam logic [T_STEP_W-1:0]       T_STEP_RST       = 16'd1040;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_T_STEP       = 1'b1;

  // curve parameter t, unsigned Q1.16 (0 .. 1.0)
  localparam int              T_FRAC = 16;
  localparam int              T_W    = 17;
  localparam logic [T_W-1:0]  T_ONE  = 17'h10000;

  // guard fraction bits kept below the coordinate lsb during evaluation
  localparam int GUARD = 8;

  // register stages of the per-axis evaluator
  localparam int HORNER_LAT = 7;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

@@ src/bcs_seq.sv @@
`timescale 1ns / 1ps

module bcs_seq #(
  parameter int CW          = 20,
  parameter int MAX_SAMPLES = 64
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     adv,
  input  logic                                     s_valid,
  output logic                                     s_ready,
  input  logic signed [CW-1:0]                     pts [8],
  input  logic [bcs_pkg::SAMPLE_COUNT_W-1:0]       sample_count,
  input  logic [bcs_pkg::T_STEP_W-1:0]             t_step,
  output logic signed [CW+3:0]                     coef_a [2],
  output logic signed [CW+3:0]                     coef_b [2],
  output logic signed [CW+3:0]                     coef_c [2],
  output logic signed [CW-1:0]                     origin [2],
  output bcs_pkg::ctl_t                            g_ctl,
  output logic [$clog2(MAX_SAMPLES)-1:0]           g_idx,
  output logic [bcs_pkg::T_W-1:0]                  g_t
);

  localparam int K      = CW + 4;
  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int TACC_W = bcs_pkg::T_STEP_W + IDX_W;
  localparam int SCW    = bcs_pkg::SAMPLE_COUNT_W;

  logic              busy;
  logic [IDX_W-1:0]  cnt;
  logic [IDX_W-1:0]  n_last;
  logic [IDX_W-1:0]  n_last_next;
  logic [TACC_W-1:0] tacc;
  logic [SCW-1:0]    n_eff;
  logic              is_last;
  logic [bcs_pkg::T_W-1:0] t_sel;
  logic signed [K-1:0] a_next [2];
  logic signed [K-1:0] b_next [2];
  logic signed [K-1:0] c_next [2];

  // power-basis coefficients, one set per axis
  always_comb begin
    logic signed [K-1:0] q0, q1, q2, q3, d10, d21;
    for (int ax = 0; ax < 2; ax++) begin
      q0  = K'(pts[ax]);
      q1  = K'(pts[2 + ax]);
      q2  = K'(pts[4 + ax]);
      q3  = K'(pts[6 + ax]);
      d10 = q1 - q0;
      d21 = q2 - q1;
      c_next[ax] = (d10 <<< 1) + d10;
      b_next[ax] = (d21 <<< 1) + d21 - c_next[ax];
      a_next[ax] = q3 - q0 - c_next[ax] - b_next[ax];
    end
  end

  // clamp the sample count to 2 .. MAX_SAMPLES
  always_comb begin
    if (sample_count < SCW'(2)) begin
      n_eff = SCW'(2);
    end else if (sample_count > SCW'(MAX_SAMPLES)) begin
      n_eff = SCW'(MAX_SAMPLES);
    end else begin
      n_eff = sample_count;
    end
    n_last_next = IDX_W'(n_eff - SCW'(1));
  end

  assign is_last = (cnt == n_last);
  assign t_sel   = (is_last || (tacc > TACC_W'(bcs_pkg::T_ONE))) ? bcs_pkg::T_ONE
                                                                 : bcs_pkg::T_W'(tacc);
  assign s_ready = !busy && !g_ctl.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      g_ctl <= '0;
    end else begin
      if (s_valid && s_ready) begin
        busy <= 1'b1;
      end else if (adv && busy && is_last) begin
        busy <= 1'b0;
      end
      if (adv) begin
        g_ctl.valid <= busy;
        g_ctl.last  <= busy && is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      cnt    <= '0;
      tacc   <= '0;
      n_last <= n_last_next;
      for (int ax = 0; ax < 2; ax++) begin
        coef_a[ax] <= a_next[ax];
        coef_b[ax] <= b_next[ax];
        coef_c[ax] <= c_next[ax];
        origin[ax] <= pts[ax];
      end
    end else if (adv && busy) begin
      cnt  <= cnt + 1'b1;
      tacc <= tacc + TACC_W'(t_step);
    end
    if (adv) begin
      g_idx <= cnt;
      g_t   <= t_sel;
    end
  end

endmodule

@@ src/bcs_horner.sv @@
`timescale 1ns / 1ps

module bcs_horner #(
  parameter int CW = 20
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic signed [CW+3:0]          a,
  input  logic signed [CW+3:0]          b,
  input  logic signed [CW+3:0]          c,
  input  logic signed [CW-1:0]          p0,
  input  logic [bcs_pkg::T_W-1:0]       t,
  output logic signed [CW-1:0]          pt
);

  localparam int K    = CW + 4;
  localparam int SW   = CW + 15;
  localparam int TS_W = bcs_pkg::T_W + 1;
  localparam int PW   = SW + TS_W;
  localparam int RW   = SW - bcs_pkg::GUARD;
  localparam logic signed [RW-1:0] HI = {{(RW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [RW-1:0] LO = ~HI;

  // drop the t fraction bits, round half up
  function automatic logic signed [SW-1:0] rnd_t(input logic signed [PW-1:0] m);
    logic signed [PW-1:0] r;
    r = m + (PW'(1) <<< (bcs_pkg::T_FRAC - 1));
    return r[SW+bcs_pkg::T_FRAC-1:bcs_pkg::T_FRAC];
  endfunction

  function automatic logic signed [SW-1:0] guard_ext(input logic signed [K-1:0] v);
    logic signed [SW-1:0] e;
    e = SW'(v);
    return e <<< bcs_pkg::GUARD;
  endfunction

  logic signed [SW-1:0] a_g, b_g, c_g, o_g;
  logic signed [SW-1:0] fin_r;
  logic signed [RW-1:0] fin;

  logic signed [PW-1:0] m1, m3, m5;
  logic signed [SW-1:0] s2, s4, s6;
  logic signed [K-1:0]  b1, c1, c2, c3;
  logic signed [CW-1:0] o1, o2, o3, o4, o5;
  logic [bcs_pkg::T_W-1:0] t1, t2, t3, t4;

  assign a_g = guard_ext(a);
  assign b_g = guard_ext(b1);
  assign c_g = guard_ext(c3);
  assign o_g = guard_ext(K'(o5));

  // final rounding off the guard bits
  assign fin_r = s6 + (SW'(1) <<< (bcs_pkg::GUARD - 1));
  assign fin   = fin_r[SW-1:bcs_pkg::GUARD];

  always_ff @(posedge clk) begin
    if (adv) begin
      // a*t
      m1 <= a_g * $signed({1'b0, t});
      b1 <= b;
      c1 <= c;
      o1 <= p0;
      t1 <= t;
      // + b
      s2 <= rnd_t(m1) + b_g;
      c2 <= c1;
      o2 <= o1;
      t2 <= t1;
      // * t
      m3 <= s2 * $signed({1'b0, t2});
      c3 <= c2;
      o3 <= o2;
      t3 <= t2;
      // + c
      s4 <= rnd_t(m3) + c_g;
      o4 <= o3;
      t4 <= t3;
      // * t
      m5 <= s4 * $signed({1'b0, t4});
      o5 <= o4;
      // + p0
      s6 <= rnd_t(m5) + o_g;
      // round and saturate
      if (fin > HI) begin
        pt <= HI[CW-1:0];
      end else if (fin < LO) begin
        pt <= LO[CW-1:0];
      end else begin
        pt <= fin[CW-1:0];
      end
    end
  end

endmodule

@@ src/cubic_bezier_sampler_unit.sv @@
`timescale 1ns / 1ps

// cubic bezier sampler: each input item is one cubic segment (four 2d control points,
// signed q16.4). the block forms the power-basis coefficients and emits n output items,
// one per cycle unless stalled, with t = i*t_step (unsigned q1.16, saturating at 1.0) and
// the final point forced to t = 1.0 so it lands exactly on p3. n is sample_count clamped
// to 2..MAX_SAMPLES. each point is ((a*t+b)*t+c)*t+p0 with 8 guard bits, rounded half up
// and saturated. the sample generator issues one t value per cycle unless stalled and
// accepts the next segment once its output stage has drained. each point passes the
// generator stage, then the 7-stage evaluator: three multiplies by t, each followed by a
// round-and-add stage, then the final round/saturate. a stall on the output freezes the
// whole pipeline; nothing is dropped or repeated. the user must write the config registers
// (sample_count at index 0, t_step at index 1) only while idle; not enforced by the block.

module cubic_bezier_sampler_unit #(
  parameter int MAX_SAMPLES = 64,
  parameter int COORD_WIDTH = 20
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // config write port
  input  logic                                      cfg_we,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [bcs_pkg::CFG_DATA_W-1:0]            cfg_data,
  // segment input
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
  input  logic [((8*COORD_WIDTH+7)/8)*8-1:0]        s_tdata,
  // point output
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // pt_x, pt_y, sample_index, zero padding
  output logic [((2*COORD_WIDTH+$clog2(MAX_SAMPLES)+7)/8)*8-1:0] m_tdata,
  output logic                                      m_tlast
);

  localparam int CW    = COORD_WIDTH;
  localparam int K     = CW + 4;
  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int OUT_W = ((2*CW + IDX_W + 7)/8)*8;
  localparam int LAT   = bcs_pkg::HORNER_LAT;

  // config registers
  logic [bcs_pkg::SAMPLE_COUNT_W-1:0] sample_count;
  logic [bcs_pkg::T_STEP_W-1:0]       t_step;

  // generator outputs
  logic signed [CW-1:0] pts [8];
  logic signed [K-1:0]  coef_a [2];
  logic signed [K-1:0]  coef_b [2];
  logic signed [K-1:0]  coef_c [2];
  logic signed [CW-1:0] origin [2];
  bcs_pkg::ctl_t        g_ctl;
  logic [IDX_W-1:0]     g_idx;
  logic [bcs_pkg::T_W-1:0] g_t;

  // sideband that travels alongside the evaluators
  bcs_pkg::ctl_t        ctl_pipe [LAT];
  logic [IDX_W-1:0]     idx_pipe [LAT];
  logic signed [CW-1:0] pt_x, pt_y;
  logic [IDX_W-1:0]     out_idx;

  // whole pipeline moves when the output register is free or being taken
  logic adv;
  assign adv = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= bcs_pkg::SAMPLE_COUNT_RST;
      t_step       <= bcs_pkg::T_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bcs_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_data[bcs_pkg::SAMPLE_COUNT_W-1:0];
        bcs_pkg::REG_T_STEP:       t_step       <= cfg_data[bcs_pkg::T_STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pts[k] = s_tdata[k*CW +: CW];
    end
  end

  bcs_seq #(
    .CW          (CW),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .s_valid      (s_tvalid),
    .s_ready      (s_tready),
    .pts          (pts),
    .sample_count (sample_count),
    .t_step       (t_step),
    .coef_a       (coef_a),
    .coef_b       (coef_b),
    .coef_c       (coef_c),
    .origin       (origin),
    .g_ctl        (g_ctl),
    .g_idx        (g_idx),
    .g_t          (g_t)
  );

  bcs_horner #(.CW(CW)) u_horner_x (
    .clk (clk),
    .adv (adv),
    .a   (coef_a[0]),
    .b   (coef_b[0]),
    .c   (coef_c[0]),
    .p0  (origin[0]),
    .t   (g_t),
    .pt  (pt_x)
  );

  bcs_horner #(.CW(CW)) u_horner_y (
    .clk (clk),
    .adv (adv),
    .a   (coef_a[1]),
    .b   (coef_b[1]),
    .c   (coef_c[1]),
    .p0  (origin[1]),
    .t   (g_t),
    .pt  (pt_y)
  );

  // valid/last and sample index follow the evaluator stage by stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) begin
        ctl_pipe[k] <= '0;
      end
    end else if (adv) begin
      ctl_pipe[0] <= g_ctl;
      for (int k = 1; k < LAT; k++) begin
        ctl_pipe[k] <= ctl_pipe[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_pipe[0] <= g_idx;
      for (int k = 1; k < LAT; k++) begin
        idx_pipe[k] <= idx_pipe[k-1];
      end
    end
  end

  assign out_idx  = idx_pipe[LAT-1];
  assign m_tvalid = ctl_pipe[LAT-1].valid;
  assign m_tlast  = ctl_pipe[LAT-1].last;
  assign m_tdata  = OUT_W'({out_idx, pt_y, pt_x});

  // a new segment is only taken with the generator stage empty
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !g_ctl.valid)
    else $error("generator stage busy after segment accept");

  // every segment has at least two points, so the first one is never the last
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tlast && (out_idx == '0)))
    else $error("last flag on sample zero");

  // the generator holds its stage while the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(g_ctl) && $stable(g_idx))
    else $error("generator moved during stall");

  // after issuing the last sample the generator goes idle
  assert property (@(posedge clk) disable iff (rst)
    g_ctl.valid && g_ctl.last && adv |=> !g_ctl.valid)
    else $error("sample issued after last of segment");

endmodule

@@ sim/tb_cubic_bezier_sampler_unit.sv @@
`timescale 1ns / 1ps

module tb_cubic_bezier_sampler_unit;

  localparam int CW = 20;
  localparam int MAXN = 64;
  localparam int SW = ((8 * CW + 7) / 8) * 8;
  localparam int MW = ((2 * CW + $clog2(MAXN) + 7) / 8) * 8;
  localparam longint SAT_HI = 524287;
  localparam longint SAT_LO = -524288;
  localparam longint T_UNITY = 65536;
  localparam logic signed [CW-1:0] CMAX = 20'sh7FFFF;
  localparam logic signed [CW-1:0] CMIN = 20'sh80000;

  // one segment, p0_x in the lowest bits so it maps straight onto s_tdata
  typedef struct packed {
    logic signed [CW-1:0] p3_y, p3_x, p2_y, p2_x, p1_y, p1_x, p0_y, p0_x;
  } seg_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [5:0]           idx;
    logic                 is_end;
  } curve_pt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [bcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
  logic [SW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // pt_x, pt_y, sample_index, zero padding
  logic [MW-1:0] m_tdata;
  logic m_tlast;

  // segments waiting to be offered, and sampled points still owed by the block
  seg_t seg_q[$];
  curve_pt_t pts_due[$];
  seg_t cur_seg;

  // shadow copies of the config registers
  int cnt_reg = int'(bcs_pkg::SAMPLE_COUNT_RST);
  int step_reg = int'(bcs_pkg::T_STEP_RST);

  // idle percentages of the sender and the receiver
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int err_cnt = 0;

  cubic_bezier_sampler_unit #(
    .MAX_SAMPLES(MAXN),
    .COORD_WIDTH(CW)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_error(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // appends a segment to the send queue
  function automatic void enqueue_seg(seg_t sg);
    seg_q.insert(seg_q.size(), sg);
  endfunction

  // floor((v + half) / 2^k), i.e. round half up
  function automatic longint rnd_shift(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  // horner evaluation with guard bits, then round and saturate to the coordinate range
  function automatic logic signed [CW-1:0] bezier_axis(longint a, longint b, longint c,
                                                       longint p0, longint t);
    longint acc;
    acc = a * (longint'(1) <<< bcs_pkg::GUARD);
    acc = rnd_shift(acc * t, bcs_pkg::T_FRAC) + b * (longint'(1) <<< bcs_pkg::GUARD);
    acc = rnd_shift(acc * t, bcs_pkg::T_FRAC) + c * (longint'(1) <<< bcs_pkg::GUARD);
    acc = rnd_shift(acc * t, bcs_pkg::T_FRAC) + p0 * (longint'(1) <<< bcs_pkg::GUARD);
    acc = rnd_shift(acc, bcs_pkg::GUARD);
    if (acc > SAT_HI) acc = SAT_HI;
    if (acc < SAT_LO) acc = SAT_LO;
    return acc[CW-1:0];
  endfunction

  // works out every point of an accepted segment and appends it to pts_due
  task automatic queue_segment_points(seg_t sg);
    longint ax, bx, cx, ay, by, cy, tu;
    int n;
    curve_pt_t pt;
    cx = 3 * (longint'(sg.p1_x) - longint'(sg.p0_x));
    bx = 3 * (longint'(sg.p2_x) - longint'(sg.p1_x)) - cx;
    ax = longint'(sg.p3_x) - longint'(sg.p0_x) - cx - bx;
    cy = 3 * (longint'(sg.p1_y) - longint'(sg.p0_y));
    by = 3 * (longint'(sg.p2_y) - longint'(sg.p1_y)) - cy;
    ay = longint'(sg.p3_y) - longint'(sg.p0_y) - cy - by;
    // out-of-range sample counts clamp to 2..MAXN
    n = cnt_reg;
    if (n < 2) n = 2;
    if (n > MAXN) n = MAXN;
    for (int i = 0; i < n; i++) begin
      tu = longint'(i) * longint'(step_reg);
      // t saturates at 1.0, and the final point always sits at t = 1.0
      if (tu > T_UNITY || i == n - 1) tu = T_UNITY;
      pt.x = bezier_axis(ax, bx, cx, longint'(sg.p0_x), tu);
      pt.y = bezier_axis(ay, by, cy, longint'(sg.p0_y), tu);
      pt.idx = i[5:0];
      pt.is_end = (i == n - 1);
      pts_due.insert(pts_due.size(), pt);
    end
  endtask

  // driver: offers queued segments, holding each until accepted
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) queue_segment_points(cur_seg);
      if (!s_tvalid || s_tready) begin
        if (seg_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_seg = seg_q.pop_front();
          s_tdata <= cur_seg;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure and field-by-field check against the oldest point owed
  always @(posedge clk) begin
    curve_pt_t exp_pt;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pts_due.size() == 0) begin
          flag_error($sformatf("unexpected point data=%h last=%b", m_tdata, m_tlast));
        end else begin
          exp_pt = pts_due.pop_front();
          if (m_tdata[CW-1:0] !== exp_pt.x || m_tdata[2*CW-1:CW] !== exp_pt.y
              || m_tdata[2*CW+5:2*CW] !== exp_pt.idx || m_tlast !== exp_pt.is_end)
            flag_error($sformatf("idx %0d: got x=%0d y=%0d i=%0d l=%b, want x=%0d y=%0d l=%b",
                                 exp_pt.idx, $signed(m_tdata[CW-1:0]),
                                 $signed(m_tdata[2*CW-1:CW]), m_tdata[2*CW+5:2*CW], m_tlast,
                                 exp_pt.x, exp_pt.y, exp_pt.is_end));
        end
      end
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // config write, only issued while the block is idle
  task automatic write_reg(logic [bcs_pkg::CFG_IDX_W-1:0] idx,
                           logic [bcs_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bcs_pkg::REG_SAMPLE_COUNT) cnt_reg = int'(val[bcs_pkg::SAMPLE_COUNT_W-1:0]);
    else step_reg = int'(val);
  endtask

  function automatic seg_t mk_seg(logic signed [CW-1:0] x0, y0, x1, y1, x2, y2, x3, y3);
    seg_t sg;
    sg.p0_x = x0; sg.p0_y = y0; sg.p1_x = x1; sg.p1_y = y1;
    sg.p2_x = x2; sg.p2_y = y2; sg.p3_x = x3; sg.p3_y = y3;
    return sg;
  endfunction

  function automatic logic signed [CW-1:0] pick_extreme();
    case ($urandom_range(3))
      0: return CMAX;
      1: return CMIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // mostly full-range coordinates, some tight clusters and some extremes
  function automatic seg_t rand_segment();
    logic [SW-1:0] raw;
    logic signed [CW-1:0] c[8];
    int sty;
    int base;
    sty = $urandom_range(9);
    base = $urandom_range(524288) - 262144;
    for (int k = 0; k < 8; k++) begin
      case (sty)
        6, 7: c[k] = CW'(base + int'($urandom_range(8191)) - 4096);
        8: c[k] = pick_extreme();
        9: c[k] = $urandom_range(1) ? pick_extreme() : CW'($urandom());
        default: c[k] = CW'($urandom());
      endcase
      raw[k*CW +: CW] = c[k];
    end
    return seg_t'(raw);
  endfunction

  function automatic void set_mode(int mode);
    case (mode)
      1: begin src_idle_pct = 71; snk_stall_pct = 0; end
      2: begin src_idle_pct = 0; snk_stall_pct = 71; end
      3: begin src_idle_pct = 24; snk_stall_pct = 24; end
      default: begin src_idle_pct = 0; snk_stall_pct = 0; end
    endcase
  endfunction

  // holds the caller until every segment is accepted and every point has come back
  task automatic wait_drained();
    while (seg_q.size() != 0 || s_tvalid || pts_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(logic [bcs_pkg::CFG_DATA_W-1:0] cnt_val,
                           logic [bcs_pkg::CFG_DATA_W-1:0] step_val,
                           int mode, int n_items);
    write_reg(bcs_pkg::REG_SAMPLE_COUNT, cnt_val);
    write_reg(bcs_pkg::REG_T_STEP, step_val);
    set_mode(mode);
    for (int k = 0; k < n_items; k++) enqueue_seg(rand_segment());
    wait_drained();
  endtask

  initial begin
    int n;
    logic [bcs_pkg::CFG_DATA_W-1:0] stp;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed segments at the reset settings (64 points, t_step 1040)
    set_mode(0);
    enqueue_seg(mk_seg('0, '0, '0, '0, '0, '0, '0, '0));
    enqueue_seg(mk_seg(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    enqueue_seg(mk_seg(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    enqueue_seg(mk_seg(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX));
    enqueue_seg(mk_seg(CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN));
    enqueue_seg(mk_seg(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN));
    enqueue_seg(mk_seg(20'sd0, 20'sd0, 20'sd5, 20'sd5, 20'sd11, 20'sd11, 20'sd16, 20'sd16));
    enqueue_seg(mk_seg('1, '1, '1, '1, '1, '1, '1, '1));
    enqueue_seg(mk_seg(20'h55555, 20'hAAAAA, 20'hAAAAA, 20'h55555,
                       20'h55555, 20'hAAAAA, 20'hAAAAA, 20'h55555));
    enqueue_seg(mk_seg(20'sd1, -20'sd1, 20'sd3, -20'sd7, -20'sd5, 20'sd2, 20'sd7, 20'sd9));
    // closed loop: start and end coincide
    enqueue_seg(mk_seg(20'sd100, 20'sd100, CMAX, CMIN, CMIN, CMAX, 20'sd100, 20'sd100));
    repeat (3) enqueue_seg(rand_segment());
    wait_drained();

    // fewest points with the largest step
    run_phase(16'd2, 16'hFFFF, 1, 60);
    // count below range acts as 2, zero step leaves every point but the last at p0
    run_phase(16'd0, 16'd0, 0, 40);
    run_phase(16'd16, 16'd4369, 2, 50);
    run_phase(16'd64, 16'd1040, 3, 30);
    // count above range acts as MAXN, large step drives t past 1.0 early
    run_phase(16'hFFFF, 16'd40000, 0, 20);
    run_phase(16'd1, 16'd21845, 2, 40);

    // random settings, mostly well-formed counts with the matching step
    repeat (8) begin
      n = ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(MAXN, 2);
      if ($urandom_range(2) == 0) stp = 16'($urandom_range(65535));
      else stp = (n < 3) ? 16'hFFFF : 16'(65536 / (n - 1));
      run_phase(16'(n) | (16'($urandom_range(511)) << 7), stp, $urandom_range(3), 20);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
src/bcs_pkg.sv
src/bcs_seq.sv
src/bcs_horner.sv
src/cubic_bezier_sampler_unit.sv
sim/tb_cubic_bezier_sampler_unit.sv
